FILE: design/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared codes, field widths and types for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 8;
  localparam int GEN_W  = 16;
  localparam int PAY_W  = 32;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_STALE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
  } fl_ctrl_t;

endpackage

FILE: design/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ght_free_list.sv
// ----------------------------------------------------------------------------
// ght_free_list
// FIFO of freed handles (slot and last generation) kept in a RAM.
// ----------------------------------------------------------------------------
module ght_free_list #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  ght_pkg::fl_ctrl_t ctrl,
  input  logic [WIDTH-1:0]  push_data,
  output logic [WIDTH-1:0]  head_data,
  output logic              not_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head  <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end else if (ctrl.push) begin
        tail  <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
    end
  end

  assign not_empty = (count != '0);

  ght_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (tail),
    .wdata (push_data),
    .re    (ctrl.rd_en),
    .raddr (head),
    .rdata (head_data)
  );

endmodule

FILE: design/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map of handles (slot, generation): add, find and free, one RAM for the
// slots and one RAM-backed FIFO for freed slots.
// ----------------------------------------------------------------------------
//   channel   dir  tdata (low bit up)                  tuser
//   s_axis    in   payload, slot_index, generation     command
//   m_axis    out  slot_out, generation_out, payload   status, found
//
// For each item the accept edge reads the slot RAM and the free list head, and
// the edge in the execute state writes back and loads the output register.
// Reset clears the counters, the state and the result valid only; data read
// from slots at or above the fresh count is never used, so no clearing pass is run.
// One result register: a new beat is taken only in the idle state, when it is empty or draining.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int SLOTS        = 256,
  parameter int GEN_BITS     = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // payload[31:0], slot_index[39:32], generation[55:40]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // slot_out[7:0], generation_out[23:8], payload_out[55:24]
  output logic [2:0]  m_axis_tuser    // status[1:0], found[2]
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = SW + GEN_BITS;
  localparam int RW = 1 + GEN_BITS + PAYLOAD_BITS;

  ght_pkg::state_t state;
  ght_pkg::state_t state_next;

  logic [ght_pkg::CMD_W-1:0]  cmd_q;
  logic [ght_pkg::PAY_W-1:0]  pay_q;
  logic [ght_pkg::SLOT_W-1:0] slot_q;
  logic [ght_pkg::GEN_W-1:0]  gen_q;
  logic [CW-1:0]              fresh_count;
  logic [CW-1:0]              fresh_count_next;

  logic                       in_accept;
  logic                       out_valid;
  logic [55:0]                out_data;
  logic [2:0]                 out_user;

  logic                       slot_re;
  logic                       slot_we;
  logic [SW-1:0]              slot_waddr;
  logic [RW-1:0]              slot_wdata;
  logic [RW-1:0]              slot_rdata;

  ght_pkg::fl_ctrl_t          fl_ctrl;
  logic [FW-1:0]              fl_push_data;
  logic [FW-1:0]              fl_head;
  logic                       fl_not_empty;

  logic                       rd_occ;
  logic [GEN_BITS-1:0]        rd_gen;
  logic [PAYLOAD_BITS-1:0]    rd_pay;
  logic                       in_range;
  logic                       live;

  logic [1:0]                 res_status;
  logic [ght_pkg::SLOT_W-1:0] res_slot;
  logic [ght_pkg::GEN_W-1:0]  res_gen;
  logic [ght_pkg::PAY_W-1:0]  res_pay;
  logic                       res_found;
  logic [SW-1:0]              add_slot;
  logic [GEN_BITS-1:0]        add_gen;

  assign s_axis_tready = (state == ght_pkg::ST_IDLE) && (!out_valid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign slot_re      = in_accept;

  assign rd_occ   = slot_rdata[RW-1];
  assign rd_gen   = slot_rdata[PAYLOAD_BITS +: GEN_BITS];
  assign rd_pay   = slot_rdata[PAYLOAD_BITS-1:0];
  assign in_range = (32'(slot_q) < 32'(fresh_count));
  assign live     = rd_occ && (ght_pkg::GEN_W'(rd_gen) == gen_q);

  always_comb begin
    state_next       = state;
    fresh_count_next = fresh_count;
    slot_we          = 1'b0;
    slot_waddr       = SW'(slot_q);
    slot_wdata       = {1'b0, rd_gen, rd_pay};
    fl_ctrl.rd_en    = in_accept;
    fl_ctrl.pop      = 1'b0;
    fl_ctrl.push     = 1'b0;
    fl_push_data     = {SW'(slot_q), rd_gen};
    add_slot         = fl_head[FW-1:GEN_BITS];
    add_gen          = fl_head[GEN_BITS-1:0] + 1'b1;
    res_status       = ght_pkg::STATUS_OK;
    res_slot         = slot_q;
    res_gen          = '0;
    res_pay          = '0;
    res_found        = 1'b0;

    unique case (state)
      ght_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        state_next = ght_pkg::ST_IDLE;
        if (cmd_q == ght_pkg::CMD_ADD) begin
          if (!fl_not_empty) begin
            add_slot = SW'(fresh_count);
            add_gen  = GEN_BITS'(1);
          end
          if (fl_not_empty || (fresh_count < CW'(SLOTS))) begin
            fl_ctrl.pop = fl_not_empty;
            if (!fl_not_empty) begin
              fresh_count_next = fresh_count + 1'b1;
            end
            slot_we    = 1'b1;
            slot_waddr = add_slot;
            slot_wdata = {1'b1, add_gen, PAYLOAD_BITS'(pay_q)};
            res_slot   = ght_pkg::SLOT_W'(add_slot);
            res_gen    = ght_pkg::GEN_W'(add_gen);
          end else begin
            res_status = ght_pkg::STATUS_FULL;
            res_slot   = '0;
          end
        end else if (cmd_q == ght_pkg::CMD_FIND || cmd_q == ght_pkg::CMD_FREE) begin
          if (!in_range) begin
            res_status = ght_pkg::STATUS_RANGE;
          end else if (!live) begin
            res_status = ght_pkg::STATUS_STALE;
            res_gen    = ght_pkg::GEN_W'(rd_gen);
          end else if (cmd_q == ght_pkg::CMD_FREE) begin
            slot_we      = 1'b1;
            fl_ctrl.push = 1'b1;
            res_gen      = ght_pkg::GEN_W'(rd_gen);
          end else begin
            res_gen   = ght_pkg::GEN_W'(rd_gen);
            res_pay   = ght_pkg::PAY_W'(rd_pay);
            res_found = 1'b1;
          end
        end
      end
      default: begin
        state_next = ght_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ght_pkg::ST_IDLE;
      fresh_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fresh_count <= fresh_count_next;
      if (state == ght_pkg::ST_EXEC) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= s_axis_tuser;
      pay_q  <= s_axis_tdata[31:0];
      slot_q <= s_axis_tdata[39:32];
      gen_q  <= s_axis_tdata[55:40];
    end
    if (state == ght_pkg::ST_EXEC) begin
      out_data <= {res_pay, res_gen, res_slot};
      out_user <= {res_found, res_status};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  ght_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (SW'(s_axis_tdata[39:32])),
    .rdata (slot_rdata)
  );

  ght_free_list #(
    .DEPTH (SLOTS),
    .WIDTH (FW)
  ) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fl_ctrl),
    .push_data (fl_push_data),
    .head_data (fl_head),
    .not_empty (fl_not_empty)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ght_pkg::ST_EXEC) && !out_valid)
    else $error("accepted beat did not enter execute with a free result register");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ght_pkg::ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fl_ctrl.pop |-> fl_not_empty && !fl_ctrl.push)
    else $error("free list popped while empty or pushed at once");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= CW'(SLOTS))
    else $error("fresh count beyond slot count");

endmodule

FILE: tb/ght_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_checker
// Watches both streams of the handle table. It keeps its own copy of the slot
// map and predicts one result per accepted command. It compares each result
// beat, field by field, with the oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------
module ght_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // payload[31:0], slot_index[39:32], generation[55:40]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // slot_out[7:0], generation_out[23:8], payload_out[55:24]
  input  logic [2:0]  m_axis_tuser,   // status[1:0], found[2]
  output int          errors,
  output int          pending
);

  localparam int NUM_SLOTS = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [15:0] gen;
    logic [31:0] payload;
    logic        found;
  } slot_result_t;

  logic [31:0]  payload_mem [NUM_SLOTS];
  logic [15:0]  gen_mem [NUM_SLOTS];
  bit           live [NUM_SLOTS];
  int           fresh_cnt;
  logic [7:0]   free_list [$];
  slot_result_t expected_results [$];

  // queues fill at the front and drain from the back
  function automatic slot_result_t table_apply(logic [1:0] cmd, logic [31:0] pay,
                                               logic [7:0] slot, logic [15:0] gen);
    slot_result_t r;
    logic [7:0]   s;
    r = '0;
    r.slot = slot;
    case (cmd)
      ght_pkg::CMD_ADD: begin
        r.slot = '0;
        if (free_list.size() > 0) begin
          s = free_list.pop_back();
          gen_mem[s] = gen_mem[s] + 16'd1;
        end else if (fresh_cnt < NUM_SLOTS) begin
          s = fresh_cnt[7:0];
          fresh_cnt++;
          gen_mem[s] = 16'd1;
        end else begin
          r.status = ght_pkg::STATUS_FULL;
          return r;
        end
        payload_mem[s] = pay;
        live[s] = 1'b1;
        r.slot = s;
        r.gen = gen_mem[s];
      end
      ght_pkg::CMD_FIND, ght_pkg::CMD_FREE: begin
        if (slot >= fresh_cnt) begin
          r.status = ght_pkg::STATUS_RANGE;
        end else begin
          r.gen = gen_mem[slot];
          if (!live[slot] || gen_mem[slot] != gen) begin
            r.status = ght_pkg::STATUS_STALE;
          end else if (cmd == ght_pkg::CMD_FREE) begin
            live[slot] = 1'b0;
            free_list.push_front(slot);
          end else begin
            r.payload = payload_mem[slot];
            r.found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    slot_result_t want;
    slot_result_t got;
    if (rst) begin
      fresh_cnt = 0;
      free_list.delete();
      expected_results.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        live[i] = 1'b0;
        gen_mem[i] = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_front(table_apply(s_axis_tuser, s_axis_tdata[31:0],
                                                s_axis_tdata[39:32], s_axis_tdata[55:40]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser[1:0];
        got.found   = m_axis_tuser[2];
        got.slot    = m_axis_tdata[7:0];
        got.gen     = m_axis_tdata[23:8];
        got.payload = m_axis_tdata[55:24];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, got %0h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_back();
          check_field("status", want.status, got.status);
          check_field("slot_out", want.slot, got.slot);
          check_field("generation_out", want.gen, got.gen);
          check_field("payload_out", want.payload, got.payload);
          check_field("found", want.found, got.found);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/generational_handle_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Drives add, find and free commands into the handle table: a directed opener,
// a short reuse of one slot through a run of generations, random traffic whose
// finds and frees mostly use handles the table handed out, and a fill to table full.
// Both streams idle at random; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module generational_handle_table_tb;

  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_MAX    = 512;

  typedef struct packed {
    logic [7:0]  slot;
    logic [15:0] gen;
  } handle_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int      errors;
  int      pending;
  int      idle_cycles;
  int      rdy_stall;
  bit      quiet;
  handle_t live_handles [$];
  logic [1:0] issued_cmds [$];

  always #4 clk = ~clk;

  generational_handle_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ght_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (rdy_stall > 0) begin
      rdy_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rdy_stall = quiet ? 0 : pick_gap();
    end
  end

  // handles returned by successful adds feed later finds and frees
  always @(posedge clk) begin : track_handles
    handle_t    h;
    logic [1:0] c;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        issued_cmds.push_front(s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready && issued_cmds.size() > 0) begin
        c = issued_cmds.pop_back();
        if (c == ght_pkg::CMD_ADD && m_axis_tuser[1:0] == ght_pkg::STATUS_OK &&
            live_handles.size() < POOL_MAX) begin
          h.slot = m_axis_tdata[7:0];
          h.gen  = m_axis_tdata[23:8];
          live_handles.push_front(h);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] pay,
                           input logic [7:0] slot, input logic [15:0] gen);
    int n;
    n = quiet ? 0 : pick_gap();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gen, slot, pay};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item();
    int         r;
    int         k;
    int         add_pct;
    handle_t    h;
    logic [1:0] cmd;
    logic [31:0] pay;
    logic [7:0] sl;
    logic [15:0] g;
    r = $urandom_range(0, 99);
    add_pct = live_handles.size() < 32 ? 45 : (live_handles.size() < 160 ? 30 : 18);
    pay = $urandom;
    sl = $urandom_range(0, 255);
    g = $urandom_range(0, 65535);
    if (r < 4) begin
      cmd = CMD_UNDEF;
    end else if (r < 14) begin
      cmd = $urandom_range(0, 1) ? ght_pkg::CMD_FIND : ght_pkg::CMD_FREE;
    end else if (r < 14 + add_pct || live_handles.size() == 0) begin
      cmd = ght_pkg::CMD_ADD;
    end else begin
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      sl = h.slot;
      g = h.gen;
      if ($urandom_range(0, 9) == 0) g = g ^ (16'd1 << $urandom_range(0, 15));
      if ($urandom_range(0, 1)) begin
        cmd = ght_pkg::CMD_FIND;
      end else begin
        cmd = ght_pkg::CMD_FREE;
        // keep some freed handles around for double frees
        if ($urandom_range(0, 7) != 0) live_handles.delete(k);
      end
    end
    if ($urandom_range(0, 19) == 0) pay = $urandom_range(0, 1) ? '1 : '0;
    send_beat(cmd, pay, sl, g);
  endtask

  initial begin : stimulus
    logic [15:0] g;
    handle_t     h;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd0, 16'd0);
    send_beat(ght_pkg::CMD_FREE, 32'h0, 8'd0, 16'd0);
    send_beat(CMD_UNDEF, 32'hffff_ffff, 8'd255, 16'hffff);
    send_beat(ght_pkg::CMD_ADD, 32'h0, 8'd0, 16'd0);
    send_beat(ght_pkg::CMD_ADD, 32'hffff_ffff, 8'd255, 16'hffff);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd0, 16'd1);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd1, 16'd1);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd1, 16'd0);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd2, 16'd1);
    send_beat(ght_pkg::CMD_FREE, 32'h0, 8'd0, 16'd1);
    send_beat(ght_pkg::CMD_FREE, 32'h0, 8'd0, 16'd1);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd0, 16'd1);
    send_beat(ght_pkg::CMD_ADD, 32'ha5a5_a5a5, 8'd0, 16'd0);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd0, 16'd2);
    send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd255, 16'hffff);
    send_beat(ght_pkg::CMD_FREE, 32'h0, 8'd1, 16'd1);
    send_beat(ght_pkg::CMD_ADD, 32'h5a5a_5a5a, 8'd0, 16'd0);
    drain();

    // slot 0 is the only one recycled here, so each add hands it back one
    // generation up
    quiet = 1'b1;
    g = 16'd2;
    for (int i = 0; i < 40; i++) begin
      send_beat(ght_pkg::CMD_FREE, $urandom, 8'd0, g);
      g = g + 16'd1;
      send_beat(ght_pkg::CMD_ADD, $urandom, $urandom_range(0, 255),
                $urandom_range(0, 65535));
      if ((i % 8) == 0) send_beat(ght_pkg::CMD_FIND, 32'h0, 8'd0, g);
    end
    drain();
    quiet = 1'b0;
    live_handles.delete();
    h.slot = 8'd0;
    h.gen = g;
    live_handles.push_front(h);
    h.slot = 8'd1;
    h.gen = 16'd2;
    live_handles.push_front(h);

    repeat (700) random_item();
    drain();

    repeat (264) send_beat(ght_pkg::CMD_ADD, $urandom, $urandom_range(0, 255),
                           $urandom_range(0, 65535));
    repeat (4) random_item();
    drain();

    for (int i = 0; i < 780; i++) begin
      quiet = (i >= 300 && i < 400);
      random_item();
    end
    quiet = 1'b0;
    drain();

    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
